[hw/rtl/rpn_pkg.sv]
// Shared constants, codes and types of the RPN stack evaluator.
`timescale 1ns / 1ps

package rpn_pkg;

  localparam int unsigned FRAC_BITS       = 16;
  localparam int unsigned DEF_STACK_DEPTH = 16;
  localparam int unsigned DEF_VALUE_WIDTH = 48;

  typedef enum logic [2:0] {
    ACT_PUSH   = 3'd0,
    ACT_ADD    = 3'd1,
    ACT_SUB    = 3'd2,
    ACT_MUL    = 3'd3,
    ACT_DIV    = 3'd4,
    ACT_SQUARE = 3'd5,
    ACT_END    = 3'd6
  } action_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_COUNT = 3'd1,
    ST_UNDER = 3'd2,
    ST_FULL  = 3'd3,
    ST_DIV0  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

endpackage

[hw/rtl/rpn_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rpn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/rpn_alu.sv]
// Shared arithmetic unit: saturating add/sub, shift-add multiply, restoring divide.
`timescale 1ns / 1ps

module rpn_alu
  import rpn_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  alu_req_t               req_i,
  input  logic [VALUE_WIDTH-1:0] a_i,
  input  logic [VALUE_WIDTH-1:0] b_i,
  output logic                   done_o,
  output logic [VALUE_WIDTH-1:0] res_o
);

  localparam int unsigned W    = VALUE_WIDTH;
  localparam int unsigned NW   = W + FRAC_BITS;
  localparam int unsigned PW   = 2 * W;
  localparam int unsigned MW   = ((PW - FRAC_BITS) > NW) ? (PW - FRAC_BITS) : NW;
  localparam int unsigned CNTW = $clog2(NW);

  localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [2:0] {
    A_IDLE,
    A_MUL,
    A_DIV,
    A_ROUND,
    A_PACK
  } alu_state_e;

  alu_state_e      state_q, state_d;
  alu_op_e         op_q, op_d;
  logic            neg_q, neg_d;
  logic [W-1:0]    ma_q, ma_d;
  logic [W-1:0]    mb_q, mb_d;
  logic [PW-1:0]   acc_q, acc_d;
  logic [W-1:0]    rem_q, rem_d;
  logic [NW-1:0]   qn_q, qn_d;
  logic [MW-1:0]   mag_q, mag_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [W-1:0]    res_q, res_d;
  logic            done_q, done_d;

  logic [W:0]      sum;
  logic [W:0]      mul_add;
  logic [W:0]      rem_shift;
  logic [W:0]      rem_diff;
  logic            rem_ge;
  logic [W-1:0]    lim;
  logic [W-1:0]    a_mag;
  logic [W-1:0]    b_mag;

  assign a_mag = a_i[W-1] ? (~a_i + W'(1)) : a_i;
  assign b_mag = b_i[W-1] ? (~b_i + W'(1)) : b_i;

  assign mul_add   = {1'b0, acc_q[PW-1:W]} + (mb_q[0] ? {1'b0, ma_q} : '0);
  assign rem_shift = {rem_q, qn_q[NW-1]};
  assign rem_diff  = rem_shift - {1'b0, mb_q};
  assign rem_ge    = rem_shift >= {1'b0, mb_q};
  assign lim       = neg_q ? VMIN : VMAX;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    neg_d   = neg_q;
    ma_d    = ma_q;
    mb_d    = mb_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    qn_d    = qn_q;
    mag_d   = mag_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    done_d  = 1'b0;
    sum     = '0;

    case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          op_d  = req_i.op;
          neg_d = a_i[W-1] ^ b_i[W-1];
          ma_d  = a_mag;
          mb_d  = b_mag;
          case (req_i.op)
            ALU_ADD, ALU_SUB: begin
              if (req_i.op == ALU_ADD) begin
                sum = {a_i[W-1], a_i} + {b_i[W-1], b_i};
              end else begin
                sum = {a_i[W-1], a_i} - {b_i[W-1], b_i};
              end
              if (sum[W] != sum[W-1]) begin
                res_d = sum[W] ? VMIN : VMAX;
              end else begin
                res_d = sum[W-1:0];
              end
              done_d = 1'b1;
            end
            ALU_MUL: begin
              acc_d   = '0;
              cnt_d   = CNTW'(W - 1);
              state_d = A_MUL;
            end
            default: begin
              rem_d   = '0;
              qn_d    = {a_mag, {FRAC_BITS{1'b0}}};
              cnt_d   = CNTW'(NW - 1);
              state_d = A_DIV;
            end
          endcase
        end
      end
      A_MUL: begin
        // add the multiplicand when the multiplier bit is set, then shift right
        acc_d = {mul_add, acc_q[W-1:1]};
        mb_d  = mb_q >> 1;
        cnt_d = cnt_q - CNTW'(1);
        if (cnt_q == '0) begin
          state_d = A_ROUND;
        end
      end
      A_DIV: begin
        // one quotient bit per cycle
        rem_d = rem_ge ? rem_diff[W-1:0] : rem_shift[W-1:0];
        qn_d  = {qn_q[NW-2:0], rem_ge};
        cnt_d = cnt_q - CNTW'(1);
        if (cnt_q == '0) begin
          state_d = A_ROUND;
        end
      end
      A_ROUND: begin
        if (op_q == ALU_MUL) begin
          // floor shift of a signed product: bump the magnitude if bits drop out
          mag_d = MW'(acc_q >> FRAC_BITS)
                + MW'(neg_q && (acc_q[FRAC_BITS-1:0] != '0));
        end else begin
          mag_d = MW'(qn_q);
        end
        state_d = A_PACK;
      end
      A_PACK: begin
        if (mag_q > MW'(lim)) begin
          res_d = lim;
        end else begin
          res_d = neg_q ? (~mag_q[W-1:0] + W'(1)) : mag_q[W-1:0];
        end
        done_d  = 1'b1;
        state_d = A_IDLE;
      end
      default: begin
        state_d = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    neg_q <= neg_d;
    ma_q  <= ma_d;
    mb_q  <= mb_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
    qn_q  <= qn_d;
    mag_q <= mag_d;
    cnt_q <= cnt_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

[hw/rtl/rpn_stack_evaluator.sv]
// Top level of the RPN stack evaluator: token sequencer, operand stack and result register.
`timescale 1ns / 1ps

// Reverse Polish evaluator. Each token arrives as one input transaction: tuser
// carries the action (push, add, subtract, multiply, divide, square, end) and
// tdata the signed Q32.16 push value (other actions ignore it). Binary operators
// pop top t and next u and push u op t; square replaces the top with its square.
// Add, subtract, multiply and square saturate; divide truncates toward zero and
// saturates an out-of-range quotient. Underflow, a push onto a full stack and a
// zero divisor leave the stack unchanged and record a sticky error (first one
// wins). The end token emits one output transaction: tdata holds the value,
// tuser the status (ok, count not one, underflow, stack full, divide by zero);
// the value is zero unless the status is ok. End then clears stack and error.
// Action code 7 is dropped without effect. One token at a time: the input is
// ready only in idle, and end waits until the output register is free.
// Multiply, square and divide run on the shared arithmetic unit, which resolves
// one product or quotient bit per cycle. The output register lets a finished
// result wait for the sink while push tokens keep flowing.
module rpn_stack_evaluator
  import rpn_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int unsigned VALUE_WIDTH = DEF_VALUE_WIDTH,
  localparam int unsigned DW         = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // Token in
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [DW-1:0] s_axis_tdata,   // [VALUE_WIDTH-1:0] value, rest zero
  input  logic [2:0]    s_axis_tuser,   // [2:0] action
  // Result out
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [DW-1:0] m_axis_tdata,   // [VALUE_WIDTH-1:0] result_value, rest zero
  output logic [2:0]    m_axis_tuser    // [2:0] status
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_T,
    S_RD_U,
    S_CALC,
    S_END_OUT
  } seq_state_e;

  seq_state_e    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  status_e       err_q, err_d;
  action_e       op_q, op_d;
  logic [W-1:0]  t_q, t_d;
  logic          out_valid_q, out_valid_d;
  logic [W-1:0]  out_value_q, out_value_d;
  status_e       out_status_q, out_status_d;

  logic          in_fire;
  logic          out_load;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_m2;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [W-1:0]  ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [W-1:0]  ram_rdata;

  alu_req_t      alu_req;
  logic [W-1:0]  alu_a;
  logic [W-1:0]  alu_b;
  logic          alu_done;
  logic [W-1:0]  alu_res;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cnt_m1        = count_q - CW'(1);
  assign cnt_m2        = count_q - CW'(2);
  // the output register takes a new result once the old one is gone or leaving
  assign out_load      = (state_q == S_END_OUT) && (!out_valid_q || m_axis_tready);

  rpn_ram #(
    .WIDTH (W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rpn_alu #(
    .VALUE_WIDTH (W)
  ) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    err_d        = err_q;
    op_d         = op_q;
    t_d          = t_q;
    out_valid_d  = out_valid_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;

    ram_we       = 1'b0;
    ram_waddr    = count_q[AW-1:0];
    ram_wdata    = s_axis_tdata[W-1:0];
    ram_raddr    = cnt_m1[AW-1:0];

    alu_req.start = 1'b0;
    alu_req.op    = ALU_ADD;
    alu_a         = ram_rdata;
    alu_b         = ram_rdata;

    // drop the held result once the sink takes it
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d = action_e'(s_axis_tuser);
          case (action_e'(s_axis_tuser))
            ACT_PUSH: begin
              if (count_q == CW'(STACK_DEPTH)) begin
                if (err_q == ST_OK) begin
                  err_d = ST_FULL;
                end
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: begin
              if (count_q < CW'(2)) begin
                if (err_q == ST_OK) begin
                  err_d = ST_UNDER;
                end
              end else begin
                state_d = S_RD_T;
              end
            end
            ACT_SQUARE: begin
              if (count_q == '0) begin
                if (err_q == ST_OK) begin
                  err_d = ST_UNDER;
                end
              end else begin
                state_d = S_RD_T;
              end
            end
            ACT_END: begin
              ram_raddr = '0;
              state_d   = S_END_OUT;
            end
            default: begin
              // unused action code: drop
            end
          endcase
        end
      end
      S_RD_T: begin
        // top of stack is on the read port now
        if (op_q == ACT_SQUARE) begin
          alu_req.start = 1'b1;
          alu_req.op    = ALU_MUL;
          state_d       = S_CALC;
        end else begin
          t_d       = ram_rdata;
          ram_raddr = cnt_m2[AW-1:0];
          state_d   = S_RD_U;
        end
      end
      S_RD_U: begin
        alu_b = t_q;
        if (op_q == ACT_DIV && t_q == '0) begin
          if (err_q == ST_OK) begin
            err_d = ST_DIV0;
          end
          state_d = S_IDLE;
        end else begin
          alu_req.start = 1'b1;
          case (op_q)
            ACT_ADD: alu_req.op = ALU_ADD;
            ACT_SUB: alu_req.op = ALU_SUB;
            ACT_MUL: alu_req.op = ALU_MUL;
            default: alu_req.op = ALU_DIV;
          endcase
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        ram_wdata = alu_res;
        if (op_q == ACT_SQUARE) begin
          ram_waddr = cnt_m1[AW-1:0];
        end else begin
          ram_waddr = cnt_m2[AW-1:0];
        end
        if (alu_done) begin
          ram_we = 1'b1;
          if (op_q != ACT_SQUARE) begin
            count_d = cnt_m1;
          end
          state_d = S_IDLE;
        end
      end
      S_END_OUT: begin
        // hold the read on the bottom entry until the output register frees up
        ram_raddr = '0;
        if (out_load) begin
          out_valid_d = 1'b1;
          out_value_d = '0;
          if (err_q != ST_OK) begin
            out_status_d = err_q;
          end else if (count_q != CW'(1)) begin
            out_status_d = ST_COUNT;
          end else begin
            out_status_d = ST_OK;
            out_value_d  = ram_rdata;
          end
          count_d = '0;
          err_d   = ST_OK;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    t_q          <= t_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = DW'(out_value_q);
  assign m_axis_tuser  = out_status_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_done_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> state_q == S_CALC)
    else $error("arithmetic result with no operation waiting");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ST_OK && state_q != S_END_OUT) |=> err_q == $past(err_q))
    else $error("sticky error changed before end of expression");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (count_q == '0 && err_q == ST_OK && m_axis_tvalid))
    else $error("end token did not clear the stack");

  a_err_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != ST_OK) |-> out_value_q == '0)
    else $error("nonzero value reported with an error status");
`endif

endmodule
